FILE: rtl/core/etl_pkg.sv
// Shared types and codes for the expression token lexer.
// Token record, per-byte token group carried through the queue, kind codes.
// No dependencies.
package etl_pkg;

    localparam int ETL_LINE_BITS   = 16;
    localparam int ETL_COLUMN_BITS = 16;
    localparam int ETL_LENGTH_BITS = 12;

    // Most tokens one input beat can produce
    localparam int TOK_MAX = 3;

    localparam logic [3:0] K_NUM       = 4'd0;
    localparam logic [3:0] K_IDENT     = 4'd1;
    localparam logic [3:0] K_FUNC      = 4'd2;
    localparam logic [3:0] K_SEMICOLON = 4'd3;
    localparam logic [3:0] K_PLUS      = 4'd4;
    localparam logic [3:0] K_SUB       = 4'd5;
    localparam logic [3:0] K_MUL       = 4'd6;
    localparam logic [3:0] K_DIV       = 4'd7;
    localparam logic [3:0] K_OPEN      = 4'd8;
    localparam logic [3:0] K_CLOSE     = 4'd9;
    localparam logic [3:0] K_COMMA     = 4'd10;
    localparam logic [3:0] K_POW       = 4'd11;
    localparam logic [3:0] K_ASSIGN    = 4'd12;
    localparam logic [3:0] K_UNKNOWN   = 4'd13;
    localparam logic [3:0] K_EOF       = 4'd14;

    typedef struct packed {
        logic [7:0]  first;
        logic [11:0] length;
        logic [15:0] column;
        logic [15:0] line;
        logic [3:0]  kind;
    } tok_t;

    // Tokens caused by one input beat, slot 0 first
    typedef struct packed {
        logic [1:0]               cnt;
        tok_t [TOK_MAX-1:0]       toks;
    } bundle_t;

endpackage

FILE: rtl/core/etl_front.sv
// Front end of the lexer: accepts source bytes, runs the lexing mode machine
// and counters, and builds the group of tokens each byte causes.
// Depends on etl_pkg.
module etl_front
    import etl_pkg::*;
#(
    parameter int LINE_BITS   = ETL_LINE_BITS,
    parameter int COLUMN_BITS = ETL_COLUMN_BITS,
    parameter int LENGTH_BITS = ETL_LENGTH_BITS
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic [7:0] in_ch,
    input  logic    in_end,
    input  logic    q_full,
    output logic    q_push,
    output bundle_t q_data
);

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_INT     = 3'd1;
    localparam logic [2:0] M_DOT     = 3'd2;
    localparam logic [2:0] M_FRAC    = 3'd3;
    localparam logic [2:0] M_IDENT   = 3'd4;
    localparam logic [2:0] M_COMMENT = 3'd5;

    localparam int LW = (LINE_BITS > 16) ? LINE_BITS : 16;
    localparam int CW = (COLUMN_BITS > 16) ? COLUMN_BITS : 16;
    localparam int NW = (LENGTH_BITS > 12) ? LENGTH_BITS : 12;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);

    logic [2:0]             mode_reg, mode_next;
    logic [LINE_BITS-1:0]   cur_line_reg, cur_line_next;
    logic [COLUMN_BITS-1:0] cur_col_reg, cur_col_next;
    logic [LINE_BITS-1:0]   tok_line_reg, tok_line_next;
    logic [COLUMN_BITS-1:0] tok_col_reg, tok_col_next;
    logic [LENGTH_BITS-1:0] tok_len_reg, tok_len_next;
    logic [7:0]             tok_first_reg, tok_first_next;
    logic                   blank_reg, blank_next;

    logic    accept;
    bundle_t bun;

    function automatic logic [LINE_BITS-1:0] inc_line(input logic [LINE_BITS-1:0] v);
        return (v == LINE_MAX) ? v : v + LINE_ONE;
    endfunction

    function automatic logic [COLUMN_BITS-1:0] inc_col(input logic [COLUMN_BITS-1:0] v);
        return (v == COL_MAX) ? v : v + COL_ONE;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] inc_len(input logic [LENGTH_BITS-1:0] v);
        return (v == LEN_MAX) ? v : v + LEN_ONE;
    endfunction

    function automatic tok_t mk_tok(input logic [3:0] kind,
                                    input logic [LINE_BITS-1:0] line,
                                    input logic [COLUMN_BITS-1:0] col,
                                    input logic [LENGTH_BITS-1:0] len,
                                    input logic [7:0] first);
        logic [LW-1:0] lw;
        logic [CW-1:0] cw;
        logic [NW-1:0] nw;
        tok_t t;
        lw = LW'(line);
        cw = CW'(col);
        nw = NW'(len);
        t.kind   = kind;
        t.line   = lw[15:0];
        t.column = cw[15:0];
        t.length = nw[11:0];
        t.first  = first;
        return t;
    endfunction

    function automatic logic [3:0] op_kind(input logic [7:0] b);
        logic [3:0] k;
        unique case (b)
            8'h3B:   k = K_SEMICOLON;
            8'h2B:   k = K_PLUS;
            8'h2D:   k = K_SUB;
            8'h2A:   k = K_MUL;
            8'h2F:   k = K_DIV;
            8'h28:   k = K_OPEN;
            8'h29:   k = K_CLOSE;
            8'h2C:   k = K_COMMA;
            8'h5E:   k = K_POW;
            8'h3D:   k = K_ASSIGN;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb begin
        logic [1:0] n;
        logic       done;
        logic       is_digit;
        logic       is_alpha;
        logic       is_word;
        logic       is_blank;
        logic       is_nl;
        n    = 2'd0;
        done = 1'b0;
        bun  = '0;
        is_digit = (in_ch >= 8'h30) && (in_ch <= 8'h39);
        is_alpha = ((in_ch >= 8'h61) && (in_ch <= 8'h7A)) ||
                   ((in_ch >= 8'h41) && (in_ch <= 8'h5A)) || (in_ch == 8'h5F);
        is_word  = is_digit || is_alpha;
        is_blank = (in_ch == 8'h20) || ((in_ch >= 8'h09) && (in_ch <= 8'h0D));
        is_nl    = (in_ch == 8'h0A);

        mode_next      = mode_reg;
        cur_line_next  = cur_line_reg;
        cur_col_next   = cur_col_reg;
        tok_line_next  = tok_line_reg;
        tok_col_next   = tok_col_reg;
        tok_len_next   = tok_len_reg;
        tok_first_next = tok_first_reg;
        blank_next     = blank_reg;

        if (in_end) begin
            // Flush the open token, then end of file; all state back to reset
            if (mode_reg == M_INT || mode_reg == M_FRAC || mode_reg == M_DOT) begin
                bun.toks[n] = mk_tok(K_NUM, tok_line_reg, tok_col_reg, tok_len_reg,
                                     tok_first_reg);
                n = n + 2'd1;
            end else if (mode_reg == M_IDENT) begin
                bun.toks[n] = mk_tok(K_IDENT, tok_line_reg, tok_col_reg, tok_len_reg,
                                     tok_first_reg);
                n = n + 2'd1;
            end
            if (mode_reg == M_DOT) begin
                // The flushed dot moves the end-of-file column past it
                bun.toks[n] = mk_tok(K_UNKNOWN, cur_line_reg, cur_col_reg, LEN_ONE, 8'h2E);
                n = n + 2'd1;
                cur_col_next = inc_col(cur_col_reg);
            end
            if (blank_reg) begin
                bun.toks[n] = mk_tok(K_EOF, '0, '0, '0, 8'h00);
            end else begin
                bun.toks[n] = mk_tok(K_EOF, cur_line_reg, cur_col_next, '0, 8'h00);
            end
            n = n + 2'd1;
            mode_next      = M_IDLE;
            cur_line_next  = LINE_ONE;
            cur_col_next   = COL_ONE;
            tok_line_next  = '0;
            tok_col_next   = '0;
            tok_len_next   = '0;
            tok_first_next = 8'h00;
            blank_next     = 1'b0;
        end else begin
            unique case (mode_reg)
                M_DOT: begin
                    if (is_digit) begin
                        tok_len_next = inc_len(inc_len(tok_len_reg));
                        cur_col_next = inc_col(inc_col(cur_col_reg));
                        mode_next    = M_FRAC;
                        done         = 1'b1;
                    end else begin
                        bun.toks[n] = mk_tok(K_NUM, tok_line_reg, tok_col_reg, tok_len_reg,
                                             tok_first_reg);
                        n = n + 2'd1;
                        bun.toks[n] = mk_tok(K_UNKNOWN, cur_line_reg, cur_col_reg, LEN_ONE,
                                             8'h2E);
                        n = n + 2'd1;
                        cur_col_next = inc_col(cur_col_reg);
                        mode_next    = M_IDLE;
                    end
                end
                M_INT, M_FRAC: begin
                    if (is_digit) begin
                        tok_len_next = inc_len(tok_len_reg);
                        cur_col_next = inc_col(cur_col_reg);
                        done         = 1'b1;
                    end else if (in_ch == 8'h2E && mode_reg == M_INT) begin
                        // Hold the position on the dot until the next byte decides
                        mode_next = M_DOT;
                        done      = 1'b1;
                    end else begin
                        bun.toks[n] = mk_tok(K_NUM, tok_line_reg, tok_col_reg, tok_len_reg,
                                             tok_first_reg);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_IDENT: begin
                    if (is_word) begin
                        tok_len_next = inc_len(tok_len_reg);
                        cur_col_next = inc_col(cur_col_reg);
                        done         = 1'b1;
                    end else begin
                        bun.toks[n] = mk_tok((in_ch == 8'h28) ? K_FUNC : K_IDENT,
                                             tok_line_reg, tok_col_reg, tok_len_reg,
                                             tok_first_reg);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end
                end
                M_COMMENT: begin
                    if (is_nl) begin
                        cur_line_next = inc_line(cur_line_reg);
                        cur_col_next  = COL_ONE;
                        mode_next     = M_IDLE;
                    end else begin
                        cur_col_next = inc_col(cur_col_reg);
                    end
                    blank_next = 1'b1;
                    done       = 1'b1;
                end
                default: begin
                    mode_next = M_IDLE;
                end
            endcase

            if (!done) begin
                // Byte starts something new at the (possibly moved) position
                if (is_blank || in_ch == 8'h23) begin
                    blank_next = 1'b1;
                    if (in_ch == 8'h23) begin
                        mode_next = M_COMMENT;
                    end
                end else if (is_word) begin
                    tok_line_next  = cur_line_next;
                    tok_col_next   = cur_col_next;
                    tok_len_next   = LEN_ONE;
                    tok_first_next = in_ch;
                    mode_next      = is_digit ? M_INT : M_IDENT;
                    blank_next     = 1'b0;
                end else begin
                    bun.toks[n] = mk_tok(op_kind(in_ch), cur_line_next, cur_col_next,
                                         LEN_ONE, in_ch);
                    n = n + 2'd1;
                    blank_next = 1'b0;
                end
                if (is_nl) begin
                    cur_line_next = inc_line(cur_line_next);
                    cur_col_next  = COL_ONE;
                end else begin
                    cur_col_next = inc_col(cur_col_next);
                end
            end
        end
        bun.cnt = n;
    end

    assign q_push = accept && (bun.cnt != 2'd0);
    assign q_data = bun;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= M_IDLE;
            cur_line_reg  <= LINE_ONE;
            cur_col_reg   <= COL_ONE;
            tok_line_reg  <= '0;
            tok_col_reg   <= '0;
            tok_len_reg   <= '0;
            tok_first_reg <= 8'h00;
            blank_reg     <= 1'b0;
        end else if (accept) begin
            mode_reg      <= mode_next;
            cur_line_reg  <= cur_line_next;
            cur_col_reg   <= cur_col_next;
            tok_line_reg  <= tok_line_next;
            tok_col_reg   <= tok_col_next;
            tok_len_reg   <= tok_len_next;
            tok_first_reg <= tok_first_next;
            blank_reg     <= blank_next;
        end
    end

endmodule

FILE: rtl/core/etl_queue.sv
// Short queue of token groups between the lexer front end and the output side.
// Depends on etl_pkg.
module etl_queue
    import etl_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t head,
    output logic    full,
    output logic    empty
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    bundle_t       mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full  = (count_reg == (PW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

endmodule

FILE: rtl/core/etl_back.sv
// Output side of the lexer: walks each queued token group one token per beat
// and marks the group's final token with tlast. Depends on etl_pkg.
module etl_back
    import etl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  bundle_t     head,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [55:0] out_data,
    output logic        out_last
);

    logic [1:0] idx_reg;
    tok_t       tok;

    assign tok       = head.toks[idx_reg];
    assign out_valid = !q_empty;
    assign out_last  = (idx_reg == (head.cnt - 2'd1));
    assign out_data  = {tok.first, tok.length, tok.column, tok.line, tok.kind};
    assign q_pop     = out_valid && out_ready && out_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else if (out_valid && out_ready) begin
            // Advance within the group, back to slot 0 when it drains
            idx_reg <= out_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

FILE: rtl/core/expression_token_lexer.sv
// Streaming lexer for a small expression language: one source byte per input
// beat, tlast on the beat that ends the source (its byte is ignored). For each
// byte taken, the front end updates the lexing mode, line, column and
// open-token registers and hands the zero to three tokens the byte causes to
// a four-entry queue of token groups. The output side sends one token per
// cycle while m_tready is high, so a steady stream runs at one byte per cycle
// while bytes average at most one token; a byte causing several tokens holds
// the output for each of them, and input stalls only when the queue is full.
// Output tlast marks the final token caused by one input beat. Line, column
// and length saturate at LINE_BITS, COLUMN_BITS and LENGTH_BITS. No clearing
// pass after reset. Depends on etl_pkg, etl_front, etl_queue, etl_back.
module expression_token_lexer
    import etl_pkg::*;
#(
    parameter int LINE_BITS   = ETL_LINE_BITS,
    parameter int COLUMN_BITS = ETL_COLUMN_BITS,
    parameter int LENGTH_BITS = ETL_LENGTH_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch [7:0]
    input  logic        s_tlast,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    // token_kind [3:0], start_line [19:4], start_column [35:20],
    // token_length [47:36], first_char [55:48]
    output logic [55:0] m_tdata,
    output logic        m_tlast    // last
);

    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    bundle_t q_in;
    bundle_t q_head;

    etl_front #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_ch    (s_tdata),
        .in_end   (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    etl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    etl_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
